// ----- design/conv3x3_zero_pad_stream_unit_defines.svh -----
// Assertion macros shared by the convolution stream checker.
`ifndef CONV3X3_ZERO_PAD_STREAM_UNIT_DEFINES_SVH
`define CONV3X3_ZERO_PAD_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C3ZP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C3ZP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/c3zp_pkg.sv -----
// Shared types and constants of the 3x3 zero-padded convolution stream.
`timescale 1ns / 1ps
package c3zp_pkg;

  // Default parameter values
  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_COEF_BITS = 8;

  // Field and counter widths
  localparam int unsigned PIX_BITS        = 8;
  localparam int unsigned SUM_BITS        = 20;
  localparam int unsigned OUT_TDATA_BITS  = 24;
  localparam int unsigned CFG_IDX_BITS    = 3;
  localparam int unsigned WIDTH_REG_BITS  = 11;
  localparam int unsigned HEIGHT_REG_BITS = 13;
  localparam int unsigned IN_ROW_BITS     = 16;
  localparam int unsigned OUT_ROW_BITS    = 14;
  localparam int unsigned KERNEL_TAPS     = 3;

  // Register reset values
  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RST = 13'd1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MID    = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_reg_e;

  // Per-word flags that ride along the cell chain
  typedef struct packed {
    logic [3*KERNEL_TAPS-1:0] ok;    // tap enable, index row*3 + column
    logic                     emit;  // word produces a result
    logic                     last;  // result closes the frame
  } flags_t;

endpackage

// ----- design/c3zp_cell.sv -----
// One convolution cell: a kernel row's line delay, window taps and partial sum.
`timescale 1ns / 1ps
module c3zp_cell #(
  parameter int unsigned MAX_WIDTH = c3zp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned COEF_BITS = c3zp_pkg::DEF_COEF_BITS,
  parameter bit          HAS_LINE  = 1'b1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic [c3zp_pkg::PIX_BITS-1:0]        px_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         addr_i,
  input  logic                                 prod_i,
  input  logic [c3zp_pkg::KERNEL_TAPS-1:0]     ok_i,
  input  logic [3*COEF_BITS-1:0]               coef_row_i,
  input  logic [c3zp_pkg::SUM_BITS-1:0]        psum_i,
  output logic [c3zp_pkg::PIX_BITS-1:0]        tap_o,
  output logic [c3zp_pkg::SUM_BITS-1:0]        psum_o
);

  localparam int unsigned PB = c3zp_pkg::PIX_BITS;
  localparam int unsigned SB = c3zp_pkg::SUM_BITS;
  localparam int unsigned NT = c3zp_pkg::KERNEL_TAPS;
  localparam int unsigned PW = COEF_BITS + PB + 1;
  localparam int unsigned MW = (PW > SB) ? PW : SB;

  logic [PB-1:0]               win_q [NT];
  logic signed [COEF_BITS-1:0] coef_s [NT];
  logic signed [PB:0]          pix_s [NT];
  logic signed [MW-1:0]        prod [NT];
  logic [SB-1:0]               term [NT];
  logic [SB-1:0]               psum_d;
  logic [SB-1:0]               psum_q;

  // Window row: newest pixel enters at tap 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NT; j++) win_q[j] <= '0;
    end else if (shift_i) begin
      win_q[0] <= px_i;
      for (int j = 1; j < NT; j++) win_q[j] <= win_q[j-1];
    end
  end

  // Line delay to the next cell
  if (HAS_LINE) begin : g_line
    logic [PB-1:0] line_mem [MAX_WIDTH];
    logic [PB-1:0] tap_q;

    always_ff @(posedge clk_i) begin
      if (shift_i) begin
        line_mem[addr_i] <= px_i;
        tap_q            <= line_mem[addr_i];
      end
    end

    assign tap_o = tap_q;
  end else begin : g_no_line
    assign tap_o = '0;
  end

  // Three masked products; tap j takes the coefficient of column 2-j
  always_comb begin
    for (int j = 0; j < NT; j++) begin
      coef_s[j] = coef_row_i[(NT-1-j)*COEF_BITS +: COEF_BITS];
      pix_s[j]  = {1'b0, win_q[j]};
      prod[j]   = coef_s[j] * pix_s[j];
      term[j]   = ok_i[j] ? prod[j][SB-1:0] : '0;
    end
    psum_d = psum_i + term[0] + term[1] + term[2];
  end

  // Partial sum handed to the next cell
  always_ff @(posedge clk_i) begin
    if (prod_i) psum_q <= psum_d;
  end

  assign psum_o = psum_q;

endmodule

// ----- design/c3zp_ctrl.sv -----
// Raster position tracking, border masks and frame end for the convolution stream.
`timescale 1ns / 1ps
module c3zp_ctrl #(
  parameter int unsigned MAX_WIDTH = c3zp_pkg::DEF_MAX_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   acc_i,
  input  logic                                   action_i,
  input  logic [c3zp_pkg::PIX_BITS-1:0]          pixel_i,
  input  logic [c3zp_pkg::WIDTH_REG_BITS-1:0]    cfg_width_i,
  input  logic [c3zp_pkg::HEIGHT_REG_BITS-1:0]   cfg_height_i,
  output logic                                   enter_o,
  output logic [$clog2(MAX_WIDTH)-1:0]           addr_o,
  output logic [c3zp_pkg::PIX_BITS-1:0]          pixel_o,
  output c3zp_pkg::flags_t                       flags_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB  = c3zp_pkg::HEIGHT_REG_BITS;
  localparam int unsigned IRB = c3zp_pkg::IN_ROW_BITS;
  localparam int unsigned ORB = c3zp_pkg::OUT_ROW_BITS;

  logic [CW-1:0]  in_col_q, in_col_d;
  logic [IRB-1:0] in_row_q, in_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [ORB-1:0] out_row_q, out_row_d;

  logic [HB-1:0]  wx;
  logic [HB-1:0]  w13;
  logic [WW-1:0]  w;
  logic [HB-1:0]  h;
  logic           in_frame;
  logic           drop;
  logic [CW-1:0]  c;
  logic [WW-1:0]  c_nx;
  logic           started;
  logic [WW-1:0]  oc_nx;
  logic [ORB:0]   or_nx;
  logic           col_end;
  logic [2:0]     row_ok;
  logic [2:0]     col_ok;
  logic           last;

  // Effective frame size and this word's position
  always_comb begin
    wx       = HB'(cfg_width_i);
    w13      = (wx == '0) ? HB'(1) : ((wx > HB'(MAX_WIDTH)) ? HB'(MAX_WIDTH) : wx);
    w        = w13[WW-1:0];
    h        = (cfg_height_i == '0) ? HB'(1) : cfg_height_i;
    in_frame = in_row_q < IRB'(h);
    drop     = action_i && in_frame;
    c        = (WW'(in_col_q) >= w) ? '0 : in_col_q;
    c_nx     = WW'(c) + WW'(1);
    started  = (in_row_q >= IRB'(2)) || ((in_row_q == IRB'(1)) && (c != '0));
    oc_nx    = WW'(out_col_q) + WW'(1);
    or_nx    = (ORB+1)'(out_row_q) + (ORB+1)'(1);
    col_end  = oc_nx >= w;
    last     = (or_nx >= (ORB+1)'(h)) && col_end;
  end

  // Border masks: row k is out_row+1-k, column j is out_col+1-j
  always_comb begin
    row_ok[0] = or_nx < (ORB+1)'(h);
    row_ok[1] = out_row_q < ORB'(h);
    row_ok[2] = (out_row_q != '0) && (out_row_q <= ORB'(h));
    col_ok[0] = oc_nx < w;
    col_ok[1] = WW'(out_col_q) < w;
    col_ok[2] = (out_col_q != '0) && (WW'(out_col_q) <= w);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        flags_o.ok[k*3 + j] = row_ok[k] && col_ok[j];
      end
    end
    flags_o.emit = started;
    flags_o.last = last;
  end

  assign enter_o = acc_i && !drop;
  assign addr_o  = c;
  assign pixel_o = (!action_i && in_frame) ? pixel_i : '0;

  // Counter updates; frame end clears everything
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (enter_o) begin
      if (c_nx >= w) begin
        in_col_d = '0;
        if (in_row_q != '1) in_row_d = in_row_q + IRB'(1);
      end else begin
        in_col_d = c_nx[CW-1:0];
      end
      if (started) begin
        priority if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (col_end) begin
          out_col_d = '0;
          out_row_d = or_nx[ORB-1:0];
        end else begin
          out_col_d = oc_nx[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ----- design/conv3x3_zero_pad_stream_unit.sv -----
// A result word moves through the stage registers to the master side once the input word
// that completes it is accepted (pixel n completes with input word n+width+1).
// Throughput, unless the master side stalls: one word per clock, the four-stage chain
// advancing every clock; each line-memory cell reads and writes one address per word.
// Reset (async, active low): counters, window taps, stage valids and config registers
// return to reset values at once; line memories are left as they are, no clearing pass.
`timescale 1ns / 1ps
module conv3x3_zero_pad_stream_unit #(
  parameter int unsigned MAX_WIDTH = c3zp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned COEF_BITS = c3zp_pkg::DEF_COEF_BITS,
  localparam int unsigned KW       = 3 * COEF_BITS,
  localparam int unsigned CFG_BITS =
    (KW > c3zp_pkg::HEIGHT_REG_BITS) ? KW : c3zp_pkg::HEIGHT_REG_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave side
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [c3zp_pkg::PIX_BITS-1:0]         s_axis_tdata,   // [7:0] pixel
  input  logic                                  s_axis_tuser,   // [0] action
  // master side
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [c3zp_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,   // [19:0] filtered_sum
  output logic                                  m_axis_tlast,   // frame_last
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [c3zp_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [CFG_BITS-1:0]                   cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PB = c3zp_pkg::PIX_BITS;
  localparam int unsigned SB = c3zp_pkg::SUM_BITS;
  localparam int unsigned NS = 4;
  localparam int unsigned NC = 3;
  localparam logic [KW-1:0] MID_RST = KW'(64'd1 << COEF_BITS);

  // Configuration registers
  logic [KW-1:0]                            k_top_q, k_mid_q, k_bot_q;
  logic [c3zp_pkg::WIDTH_REG_BITS-1:0]      width_q;
  logic [c3zp_pkg::HEIGHT_REG_BITS-1:0]     height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_top_q  <= '0;
      k_mid_q  <= MID_RST;
      k_bot_q  <= '0;
      width_q  <= c3zp_pkg::WIDTH_RST;
      height_q <= c3zp_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (c3zp_pkg::cfg_reg_e'(cfg_idx_i))
        c3zp_pkg::CFG_KERNEL_TOP:    k_top_q  <= cfg_data_i[KW-1:0];
        c3zp_pkg::CFG_KERNEL_MID:    k_mid_q  <= cfg_data_i[KW-1:0];
        c3zp_pkg::CFG_KERNEL_BOTTOM: k_bot_q  <= cfg_data_i[KW-1:0];
        c3zp_pkg::CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[c3zp_pkg::WIDTH_REG_BITS-1:0];
        c3zp_pkg::CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[c3zp_pkg::HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking
  logic                  acc;
  logic                  enter;
  logic [CW-1:0]         addr_in;
  logic [PB-1:0]         pix_in;
  c3zp_pkg::flags_t      flags_in;

  assign acc = s_axis_tvalid && s_axis_tready;

  c3zp_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .action_i     (s_axis_tuser),
    .pixel_i      (s_axis_tdata),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .enter_o      (enter),
    .addr_o       (addr_in),
    .pixel_o      (pix_in),
    .flags_o      (flags_in)
  );

  // Stage occupancy; bubbles collapse, the last stage is the output register
  logic [NS-1:0]     v_q, v_d;
  logic [NS-1:0]     adv;
  logic [NS-1:0]     free;
  c3zp_pkg::flags_t  flags_q [NS];
  logic [CW-1:0]     addr0_q;

  always_comb begin
    adv[NS-1]  = v_q[NS-1] && (!flags_q[NS-1].emit || m_axis_tready);
    free[NS-1] = !v_q[NS-1] || adv[NS-1];
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k]  = v_q[k] && free[k+1];
      free[k] = !v_q[k] || adv[k];
    end
    v_d[0] = enter || (v_q[0] && !adv[0]);
    for (int k = 1; k < NS; k++) begin
      v_d[k] = adv[k-1] || (v_q[k] && !adv[k]);
    end
  end

  assign s_axis_tready = free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  always_ff @(posedge clk_i) begin
    if (enter) begin
      flags_q[0] <= flags_in;
      addr0_q    <= addr_in;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k-1]) flags_q[k] <= flags_q[k-1];
    end
  end

  // Cell chain: cell k shifts when a word enters stage k and sums as it leaves
  logic          shift_v [NC];
  logic [PB-1:0] px_v    [NC];
  logic [CW-1:0] addr_v  [NC];
  logic [KW-1:0] coef_v  [NC];
  logic [SB-1:0] psin_v  [NC];
  logic [PB-1:0] tap_v   [NC];
  logic [SB-1:0] psum_v  [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      shift_v[k] = (k == 0) ? enter   : adv[k-1];
      px_v[k]    = (k == 0) ? pix_in  : tap_v[k-1];
      addr_v[k]  = (k == 0) ? addr_in : addr0_q;
      psin_v[k]  = (k == 0) ? '0      : psum_v[k-1];
    end
    coef_v[0] = k_bot_q;
    coef_v[1] = k_mid_q;
    coef_v[2] = k_top_q;
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    c3zp_cell #(
      .MAX_WIDTH (MAX_WIDTH),
      .COEF_BITS (COEF_BITS),
      .HAS_LINE  (k < NC - 1)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift_v[k]),
      .px_i       (px_v[k]),
      .addr_i     (addr_v[k]),
      .prod_i     (adv[k]),
      .ok_i       (flags_q[k].ok[3*k +: 3]),
      .coef_row_i (coef_v[k]),
      .psum_i     (psin_v[k]),
      .tap_o      (tap_v[k]),
      .psum_o     (psum_v[k])
    );
  end

  // Result word
  assign m_axis_tvalid = v_q[NS-1] && flags_q[NS-1].emit;
  assign m_axis_tlast  = flags_q[NS-1].last;
  assign m_axis_tdata  = c3zp_pkg::OUT_TDATA_BITS'(psum_v[NC-1]);

endmodule

// ----- design/c3zp_checker.sv -----
// Port-level checks of the convolution stream, bound to the top level.
`timescale 1ns / 1ps
`include "conv3x3_zero_pad_stream_unit_defines.svh"
module c3zp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [c3zp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic                                m_axis_tlast
);

  // A stalled result word holds its contents
  `C3ZP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")

  // Input only backs up when a result word is stuck on the master side
  `C3ZP_ASSERT_NOW(a_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // Padding above the sum stays zero
  `C3ZP_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[c3zp_pkg::OUT_TDATA_BITS-1:c3zp_pkg::SUM_BITS] == '0, "tdata padding not zero")

endmodule

bind conv3x3_zero_pad_stream_unit c3zp_checker u_c3zp_checker (.*);
